/* hw/rtl/btks_pkg.sv */
// ============================================================================
// btks_pkg: shared types and constants of the bounded top-k key set
// Holds the transaction structs, status codes, cell control and the FSM type.
// ============================================================================
package btks_pkg;

    localparam int KEY_W        = 32;
    localparam int CNT_W        = 7;
    localparam int DEF_CAPACITY = 64;

    // Leaves gathered by one node of the registered max-key tree.
    localparam int GRP_SIZE = 8;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int APB_IDX_W  = APB_ADDR_W - 2;
    localparam logic [APB_IDX_W-1:0] REG_MAX_ENTRIES = '0;
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RESET = 7'd64;

    localparam logic MODE_ADD = 1'b0;
    localparam logic MODE_DEL = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_DELETED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic                    mode;
        logic signed [KEY_W-1:0] key;
    } t_in;

    typedef struct packed {
        t_status                 status;
        logic                    evicted_valid;
        logic signed [KEY_W-1:0] evicted_key;
        logic [CNT_W-1:0]        entry_count;
        logic signed [KEY_W-1:0] min_key;
        logic signed [KEY_W-1:0] max_key;
        logic                    is_empty;
    } t_out;

    // What every cell of the chain does at the next clock edge.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_EVICT,
        OP_DELETE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     cmp;
    } t_cell_ctrl;

    // What a cell shows its neighbors: its key and whether it is below the probe.
    typedef struct packed {
        logic                    lt;
        logic signed [KEY_W-1:0] key;
    } t_link;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_GRP,
        S_FIN
    } t_state;

endpackage

/* hw/rtl/btks_cell.sv */
// ============================================================================
// btks_cell: one slot of the sorted key chain
// Holds one key, compares it with the probe key and moves keys to or from
// its neighbors on insert, evict and delete.
// ============================================================================
module btks_cell (
    input  logic                              i_clk,
    input  btks_pkg::t_cell_ctrl              i_ctrl,
    input  logic                              i_valid,
    input  logic signed [btks_pkg::KEY_W-1:0] i_probe,
    input  logic signed [btks_pkg::KEY_W-1:0] i_new_key,
    input  btks_pkg::t_link                   i_left,
    input  btks_pkg::t_link                   i_right,
    output btks_pkg::t_link                   o_link,
    output logic                              o_eq
);

    logic signed [btks_pkg::KEY_W-1:0] r_key;
    logic signed [btks_pkg::KEY_W-1:0] n_key;
    logic                              r_lt;
    logic                              r_eq;

    // The lt flags of a sorted chain form a prefix, so each cell finds its
    // own move from its flag and the flag of one neighbor.
    always_comb begin
        n_key = r_key;
        unique case (i_ctrl.op)
            btks_pkg::OP_HOLD: begin
                n_key = r_key;
            end
            btks_pkg::OP_INSERT: begin
                if (!r_lt) begin
                    n_key = i_left.lt ? i_new_key : $signed(i_left.key);
                end
            end
            btks_pkg::OP_EVICT: begin
                if (i_right.lt) begin
                    n_key = $signed(i_right.key);
                end else if (r_lt) begin
                    n_key = i_new_key;
                end
            end
            btks_pkg::OP_DELETE: begin
                if (!r_lt) begin
                    n_key = $signed(i_right.key);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (i_ctrl.cmp) begin
            r_lt <= i_valid && (r_key < i_probe);
            r_eq <= i_valid && (r_key == i_probe);
        end
    end

    assign o_link.lt  = r_lt;
    assign o_link.key = r_key;
    assign o_eq       = r_eq;

endmodule

/* hw/rtl/bounded_top_k_key_set_unit.sv */
// ============================================================================
// bounded_top_k_key_set_unit: sorted set that keeps only the largest keys
// Steps: compare at the accept edge, chain shift, then the two levels of the
// registered max-key tree. A new transaction is taken only after the last
// result is loaded, so a stalled result register holds off the next one.
// Reset: synchronous, active low; the set becomes empty and max_entries
// returns to 64. No clearing pass is run; keys above the count are never read.
// ============================================================================
module bounded_top_k_key_set_unit #(
    parameter int CAPACITY = btks_pkg::DEF_CAPACITY
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  btks_pkg::t_in                       i_in,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output btks_pkg::t_out                      o_out,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [btks_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [btks_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [btks_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CNT_IW = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_IW > btks_pkg::CNT_W) ? CNT_IW : btks_pkg::CNT_W;
    localparam int NGRP   = (CAPACITY + btks_pkg::GRP_SIZE - 1) / btks_pkg::GRP_SIZE;
    localparam int NLEAF  = NGRP * btks_pkg::GRP_SIZE;

    // ------------------------------------------------------------------------
    // Control state.
    // ------------------------------------------------------------------------
    btks_pkg::t_state                  r_state;
    btks_pkg::t_state                  n_state;
    logic [CNT_IW-1:0]                 r_count;
    logic [btks_pkg::CNT_W-1:0]        r_max_entries;
    logic                              r_out_valid;

    // Transaction and per-step results held between stages.
    logic                              r_mode;
    logic signed [btks_pkg::KEY_W-1:0] r_key;
    btks_pkg::t_status                 r_status;
    logic                              r_ev_valid;
    logic signed [btks_pkg::KEY_W-1:0] r_ev_key;
    logic signed [btks_pkg::KEY_W-1:0] r_grp [NGRP];
    btks_pkg::t_out                    r_out;

    // FSM outputs.
    logic                              in_take;
    logic                              out_take;
    logic                              upd_en;
    logic                              grp_load;
    logic                              out_load;
    btks_pkg::t_cell_ctrl              cell_ctrl;

    // Chain signals.
    btks_pkg::t_link                   link   [CAPACITY];
    logic [CAPACITY-1:0]               eq_vec;
    logic [CAPACITY-1:0]               lt_vec;
    logic signed [btks_pkg::KEY_W-1:0] leaf   [NLEAF];

    // Decision of the update step.
    logic                              present;
    logic                              below_limit;
    logic [CMP_W-1:0]                  limit;
    btks_pkg::t_cell_op                upd_op;
    btks_pkg::t_status                 upd_status;
    logic                              upd_ev;
    logic [CNT_IW-1:0]                 upd_count;

    logic                              cfg_wr;
    logic signed [btks_pkg::KEY_W-1:0] max_or;

    // ------------------------------------------------------------------------
    // Handshakes. A new transaction enters only while the chain is at rest;
    // the result register frees the chain as soon as the result is loaded.
    // ------------------------------------------------------------------------
    assign in_take  = i_valid && !o_stall;
    assign out_take = r_out_valid && !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            btks_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = btks_pkg::S_UPD;
                end
            end
            btks_pkg::S_UPD: begin
                n_state = btks_pkg::S_GRP;
            end
            btks_pkg::S_GRP: begin
                n_state = btks_pkg::S_FIN;
            end
            btks_pkg::S_FIN: begin
                if (!r_out_valid || !i_stall) begin
                    n_state = btks_pkg::S_IDLE;
                end
            end
        endcase
    end

    // State outputs. The compare runs at the accept edge against the input
    // port itself, so every cell holds its flags when the update step starts.
    always_comb begin
        o_stall       = 1'b1;
        upd_en        = 1'b0;
        grp_load      = 1'b0;
        out_load      = 1'b0;
        cell_ctrl.op  = btks_pkg::OP_HOLD;
        cell_ctrl.cmp = 1'b0;
        unique case (r_state)
            btks_pkg::S_IDLE: begin
                o_stall       = 1'b0;
                cell_ctrl.cmp = i_valid;
            end
            btks_pkg::S_UPD: begin
                upd_en       = 1'b1;
                cell_ctrl.op = upd_op;
            end
            btks_pkg::S_GRP: begin
                grp_load = 1'b1;
            end
            btks_pkg::S_FIN: begin
                out_load = !r_out_valid || !i_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= btks_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // The chain. Cell i holds the i-th smallest key while i is below the
    // count. The first cell sees a left neighbor that is always below the
    // probe, so an insert in front of everything lands there; the last cell
    // sees a right neighbor that never is.
    // ------------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        btks_pkg::t_link left_in;
        btks_pkg::t_link right_in;

        if (i == 0) begin : g_first
            assign left_in.lt  = 1'b1;
            assign left_in.key = '0;
        end else begin : g_mid_l
            assign left_in = link[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_in.lt  = 1'b0;
            assign right_in.key = link[i].key;
        end else begin : g_mid_r
            assign right_in = link[i+1];
        end

        btks_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (cell_ctrl),
            .i_valid   (CNT_IW'(i) < r_count),
            .i_probe   ($signed(i_in.key)),
            .i_new_key (r_key),
            .i_left    (left_in),
            .i_right   (right_in),
            .o_link    (link[i]),
            .o_eq      (eq_vec[i])
        );

        assign lt_vec[i] = link[i].lt;

        // Leaf of the max tree: only the last valid cell passes its key.
        assign leaf[i] = (r_count == CNT_IW'(i + 1)) ? $signed(link[i].key) : '0;
    end

    for (genvar i = CAPACITY; i < NLEAF; i++) begin : g_pad
        assign leaf[i] = '0;
    end

    // ------------------------------------------------------------------------
    // Update step. The limit is max_entries clamped to one through CAPACITY;
    // the set counts as full whenever the count is at or above it, even when
    // the limit was lowered below the count.
    // ------------------------------------------------------------------------
    always_comb begin
        if (r_max_entries == '0) begin
            limit = CMP_W'(1);
        end else if (CMP_W'(r_max_entries) > CMP_W'(CAPACITY)) begin
            limit = CMP_W'(CAPACITY);
        end else begin
            limit = CMP_W'(r_max_entries);
        end
    end

    assign present     = |eq_vec;
    assign below_limit = CMP_W'(r_count) < limit;

    always_comb begin
        upd_op     = btks_pkg::OP_HOLD;
        upd_status = btks_pkg::ST_REJECTED;
        upd_ev     = 1'b0;
        upd_count  = r_count;
        if (r_mode == btks_pkg::MODE_ADD) begin
            priority if (present) begin
                upd_status = btks_pkg::ST_PRESENT;
            end else if (below_limit) begin
                upd_op     = btks_pkg::OP_INSERT;
                upd_status = btks_pkg::ST_INSERTED;
                upd_count  = r_count + CNT_IW'(1);
            end else if (lt_vec[0]) begin
                // Full and the key beats the minimum: the smallest key leaves
                // and the rest below the new key slide down by one.
                upd_op     = btks_pkg::OP_EVICT;
                upd_status = btks_pkg::ST_INSERTED;
                upd_ev     = 1'b1;
            end else begin
                upd_status = btks_pkg::ST_REJECTED;
            end
        end else begin
            if (present) begin
                upd_op     = btks_pkg::OP_DELETE;
                upd_status = btks_pkg::ST_DELETED;
                upd_count  = r_count - CNT_IW'(1);
            end else begin
                upd_status = btks_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (upd_en) begin
            r_count <= upd_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_mode <= i_in.mode;
            r_key  <= $signed(i_in.key);
        end
        if (upd_en) begin
            r_status   <= upd_status;
            r_ev_valid <= upd_ev;
            r_ev_key   <= upd_ev ? $signed(link[0].key) : '0;
        end
    end

    // ------------------------------------------------------------------------
    // Max-key tree. The first level ORs groups of leaves into registers once
    // the chain has settled; the second level feeds the result register.
    // At most one leaf is ever nonzero, so an OR selects it.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (grp_load) begin
            for (int g = 0; g < NGRP; g++) begin
                logic signed [btks_pkg::KEY_W-1:0] acc;
                acc = '0;
                for (int j = 0; j < btks_pkg::GRP_SIZE; j++) begin
                    acc = acc | leaf[g * btks_pkg::GRP_SIZE + j];
                end
                r_grp[g] <= acc;
            end
        end
    end

    always_comb begin
        max_or = '0;
        for (int g = 0; g < NGRP; g++) begin
            max_or = max_or | r_grp[g];
        end
    end

    // ------------------------------------------------------------------------
    // Result register. It holds a finished result while the chain is free to
    // take the next transaction.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.status        <= r_status;
            r_out.evicted_valid <= r_ev_valid;
            r_out.evicted_key   <= r_ev_key;
            r_out.entry_count   <= btks_pkg::CNT_W'(r_count);
            r_out.min_key       <= (r_count == '0) ? '0 : $signed(link[0].key);
            r_out.max_key       <= max_or;
            r_out.is_empty      <= (r_count == '0);
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

    // ------------------------------------------------------------------------
    // Configuration port. Writes land at the access phase; reads return the
    // limit register and zero elsewhere.
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries <= btks_pkg::MAX_ENTRIES_RESET;
        end else if (cfg_wr &&
                     (paddr[btks_pkg::APB_ADDR_W-1:2] == btks_pkg::REG_MAX_ENTRIES)) begin
            r_max_entries <= pwdata[btks_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[btks_pkg::APB_ADDR_W-1:2] == btks_pkg::REG_MAX_ENTRIES) begin
            prdata = btks_pkg::APB_DATA_W'(r_max_entries);
        end
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_IW'(r_count) <= CNT_IW'(CAPACITY))
        else $error("key count exceeds capacity");

    // Keys are distinct, so at most one cell can match the probe.
    a_eq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == btks_pkg::S_UPD) |-> $onehot0(eq_vec))
        else $error("more than one cell matches the key");

    // Only an insert can evict, and an evicting step keeps the count.
    a_evict_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (upd_en && upd_ev) |=> (r_status == btks_pkg::ST_INSERTED) &&
                               (r_count == $past(r_count)))
        else $error("eviction outside an insert or with a count change");

    // A result that reports an empty set reports a zero count.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.is_empty == (r_out.entry_count == '0)))
        else $error("empty flag disagrees with the count");

endmodule

/* sim/key_set_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// key_set_checker: result prediction and checking for the bounded top-k set
// Watches the input, result and configuration traffic, keeps its own sorted
// copy of the held keys and compares every result transaction in order.
// ============================================================================
module key_set_checker
    import btks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in                   i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_out,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_pready,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_evictions
);

    localparam int SLOTS        = DEF_CAPACITY;
    localparam int REPORT_LIMIT = 10;
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_MAX_ENTRIES, 2'b00};

    // Held keys in ascending order, and the results still owed by the block.
    logic signed [KEY_W-1:0] held_keys[$];
    t_out                    owed_results[$];
    logic [CNT_W-1:0]        limit_reg = MAX_ENTRIES_RESET;

    // Applies one add or delete to the held keys and returns the result.
    function automatic t_out apply_key_op(input t_in item);
        t_out                    res;
        logic signed [KEY_W-1:0] k;
        int                      lim;
        int                      pos;
        bit                      held;
        res = '0;
        k   = item.key;
        // The limit is clamped to 1..SLOTS, so zero behaves as one.
        if (limit_reg == 0) begin
            lim = 1;
        end else if (int'(limit_reg) > SLOTS) begin
            lim = SLOTS;
        end else begin
            lim = int'(limit_reg);
        end
        pos = 0;
        while (pos < held_keys.size() && held_keys[pos] < k) pos++;
        held = (pos < held_keys.size()) && (held_keys[pos] == k);
        if (item.mode == MODE_ADD) begin
            if (held) begin
                res.status = ST_PRESENT;
            end else if (held_keys.size() < lim) begin
                held_keys.insert(pos, k);
                res.status = ST_INSERTED;
            end else if (held_keys.size() > 0 && k > held_keys[0]) begin
                // Full: the minimum goes out and the new key goes into its sorted place.
                res.evicted_valid = 1'b1;
                res.evicted_key   = held_keys[0];
                void'(held_keys.pop_front());
                held_keys.insert(pos - 1, k);
                res.status = ST_INSERTED;
            end else begin
                res.status = ST_REJECTED;
            end
        end else begin
            if (held) begin
                held_keys.delete(pos);
                res.status = ST_DELETED;
            end else begin
                res.status = ST_NOT_FOUND;
            end
        end
        res.entry_count = CNT_W'(held_keys.size());
        if (held_keys.size() != 0) begin
            res.min_key = held_keys[0];
            res.max_key = held_keys[held_keys.size() - 1];
        end else begin
            res.is_empty = 1'b1;
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [KEY_W-1:0] want,
                                         input logic [KEY_W-1:0] got);
        if (got !== want) begin
            o_errors++;
            if (o_errors <= REPORT_LIMIT) begin
                $display("  mismatch in result %0d, %s: expected %h, got %h",
                         o_checked, name, want, got);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            held_keys.delete();
            owed_results.delete();
            limit_reg   = MAX_ENTRIES_RESET;
            o_errors    = 0;
            o_checked   = 0;
            o_evictions = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == LIMIT_ADDR) begin
                limit_reg = i_pwdata[CNT_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                owed_results.push_back(apply_key_op(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= REPORT_LIMIT) begin
                        $display("  result transaction with nothing expected: %h", i_out);
                    end
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", want.status, i_out.status);
                    check_field("evicted_valid", want.evicted_valid, i_out.evicted_valid);
                    check_field("evicted_key", want.evicted_key, i_out.evicted_key);
                    check_field("entry_count", want.entry_count, i_out.entry_count);
                    check_field("min_key", want.min_key, i_out.min_key);
                    check_field("max_key", want.max_key, i_out.max_key);
                    check_field("is_empty", want.is_empty, i_out.is_empty);
                    if (want.evicted_valid) o_evictions++;
                    o_checked++;
                end
            end
        end
        o_pending = owed_results.size();
    end

endmodule

/* sim/bounded_top_k_key_set_unit_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// bounded_top_k_key_set_unit_tb: testbench for the bounded top-k key set
// Drives add and delete transactions and limit writes into the block, with
// random idling on both channels; a separate checker predicts every result.
// ============================================================================
module bounded_top_k_key_set_unit_tb;
    import btks_pkg::*;

    localparam int RESET_CYCLES  = 8;
    // Idle time after the last result comes back, before touching the
    // limit register or deciding the verdict.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RECENT_DEPTH  = 32;
    localparam int PHASES        = 9;

    // Register 0 is the limit; address 4 decodes to an index with no register.
    localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_MAX_ENTRIES, 2'b00};
    localparam logic [APB_ADDR_W-1:0] NO_REG_ADDR = {REG_MAX_ENTRIES + 1'b1, 2'b00};

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in                   i_in    = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out                  o_out;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int key_errors;
    int results_left;
    int results_checked;
    int evictions;

    // Stimulus bookkeeping and idling knobs. An odds value of N means a
    // one-in-N chance per opportunity; zero turns that kind of idling off.
    int                      items_sent    = 0;
    int                      settings_made = 0;
    int                      gap_odds      = 0;
    int                      stall_odds    = 0;
    bit                      no_idle       = 1'b0;
    int                      stall_left    = 0;
    logic signed [KEY_W-1:0] recent[$];

    // Per phase of the random part: limit written, transaction count and
    // the share of adds in percent. The first limit is out of range and the
    // fifth is zero, both of which the block must clamp.
    int phase_limit[PHASES] = '{127, 1, 3, 64, 0, 100, 8, 2, 64};
    int phase_items[PHASES] = '{120, 30, 40, 70, 25, 35, 35, 20, 25};
    int phase_adds [PHASES] = '{90, 60, 70, 75, 60, 70, 65, 60, 55};

    bounded_top_k_key_set_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out   (o_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    key_set_checker key_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_stall  (o_stall),
        .i_in        (i_in),
        .i_out_valid (o_valid),
        .i_out_stall (i_stall),
        .i_out       (o_out),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_errors    (key_errors),
        .o_pending   (results_left),
        .o_checked   (results_checked),
        .o_evictions (evictions)
    );

    always #5 i_clk = ~i_clk;

    // Result-side back-pressure. A burst of stall_left cycles starts with a
    // one-in-stall_odds chance on any cycle outside a burst.
    always @(posedge i_clk) begin
        if (!i_rst_n || no_idle) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
            stall_left <= $urandom_range(1, 16);
            i_stall    <= 1'b1;
        end
    end

    // Picks a key. Recently used keys give hits for present and deleted
    // results, the narrow band around zero fills the set with collisions,
    // full random words toggle every bit, and the boundary keys sit at the
    // two ends of the signed range and at minus one and zero.
    function automatic logic signed [KEY_W-1:0] pick_key(input int recent_pct);
        if (recent.size() != 0 && $urandom_range(0, 99) < recent_pct) begin
            return recent[$urandom_range(0, recent.size() - 1)];
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                return KEY_W'(int'($urandom_range(0, 80)) - 40);
            end
            5, 6, 7: begin
                return $urandom;
            end
            default: begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h8000_0001;
                    2:       return 32'h7FFF_FFFF;
                    3:       return 32'h7FFF_FFFE;
                    4:       return '1;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // Offers one transaction and returns at the edge where it is taken.
    // Valid stays high into the next call unless a gap is drawn, so
    // back-to-back transactions never lower and raise valid in one step.
    task automatic send_item(input logic op, input logic signed [KEY_W-1:0] key);
        int gap;
        if (!no_idle && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= '{mode: op, key: key};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        recent.push_back(key);
        if (recent.size() > RECENT_DEPTH) void'(recent.pop_front());
    endtask

    // Stops sending and waits until every owed result has come back, then
    // lets the block's latency run out so it is truly idle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (results_left != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: a setup phase, then an access phase held until
    // pready. The trailing edge keeps two writes from meeting in one step.
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drains the block, then writes a new limit. The bits above the 7-bit
    // field carry random junk that the register must drop.
    task automatic set_limit(input int limit);
        logic [APB_DATA_W-1:0] word;
        wait_idle();
        word = ($urandom & ~APB_DATA_W'(7'h7F)) | APB_DATA_W'(limit[CNT_W-1:0]);
        write_reg(LIMIT_ADDR, word);
        settings_made++;
    endtask

    initial begin
        int p;
        int n;
        logic op;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting from the reset limit of 64. It covers a
        // delete on an empty set, both ends of the key range, a repeated
        // add, a delete of an absent key and a write to an index that has
        // no register.
        gap_odds   = 4;
        stall_odds = 6;
        send_item(MODE_DEL, 32'sd7);
        send_item(MODE_ADD, 32'sd0);
        send_item(MODE_ADD, 32'h7FFF_FFFF);
        send_item(MODE_ADD, 32'h8000_0000);
        send_item(MODE_ADD, -32'sd1);
        send_item(MODE_ADD, 32'h7FFF_FFFF);
        send_item(MODE_DEL, -32'sd1);
        send_item(MODE_DEL, -32'sd1);
        send_item(MODE_ADD, 32'sd5);
        // The write to the empty index must leave the limit at 64, so the
        // next add is a plain insert.
        wait_idle();
        write_reg(NO_REG_ADDR, 32'd2);
        send_item(MODE_ADD, 32'sd6);

        // Limit of 3 with five keys held: the set counts as full and each
        // add that wins evicts exactly one key. An add of the current
        // minimum reports present, a lower key is rejected.
        set_limit(3);
        send_item(MODE_ADD, 32'sd7);
        send_item(MODE_ADD, -32'sd100);
        send_item(MODE_ADD, 32'sd0);
        send_item(MODE_ADD, 32'sd1);

        // A limit of zero acts as one.
        set_limit(0);
        send_item(MODE_ADD, 32'sd2);
        send_item(MODE_DEL, 32'h7FFF_FFFF);
        send_item(MODE_DEL, 32'sd7);
        send_item(MODE_DEL, 32'sd6);
        send_item(MODE_DEL, 32'sd5);
        send_item(MODE_DEL, 32'sd2);
        send_item(MODE_ADD, 32'sd9);
        send_item(MODE_ADD, 32'sd3);
        send_item(MODE_ADD, 32'sd10);
        send_item(MODE_DEL, 32'sd10);

        // Random part. Every phase boundary drains the block before the
        // limit changes. Idling varies per phase, some phases run without
        // gaps, and the last phase runs with no idling at all.
        for (p = 0; p < PHASES; p++) begin
            set_limit(phase_limit[p]);
            gap_odds   = (p % 3 == 2) ? 0 : 3 + p;
            stall_odds = (p % 4 == 3) ? 0 : 4 + p;
            no_idle    = (p == PHASES - 1);
            for (n = 0; n < phase_items[p]; n++) begin
                op = ($urandom_range(0, 99) < phase_adds[p]) ? MODE_ADD : MODE_DEL;
                send_item(op, pick_key((op == MODE_ADD) ? 20 : 50));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Summary: %0d add and delete transactions under %0d limit settings,",
                 items_sent, settings_made);
        $display("Summary: %0d results checked, %0d with an eviction of the minimum key.",
                 results_checked, evictions);
        if (key_errors == 0 && results_left == 0) begin
            $display("** bounded_top_k_key_set_unit: PASSED **");
        end else begin
            $display("** bounded_top_k_key_set_unit: FAILED **");
        end
        $finish;
    end

    // Watchdog: a correct run takes a small fraction of this.
    initial begin
        #2_000_000;
        $display("** bounded_top_k_key_set_unit: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/btks_pkg.sv
hw/rtl/btks_cell.sv
hw/rtl/bounded_top_k_key_set_unit.sv
sim/key_set_checker.sv
sim/bounded_top_k_key_set_unit_tb.sv
